>>> design/mlld_pkg.sv
// Shared constants, types and label tables for the meter line label decoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package mlld_pkg;

  // Line store geometry
  localparam int LINE_BYTES = 64;
  localparam int POS_W      = $clog2(LINE_BYTES);
  localparam int CNT_W      = POS_W + 1;

  // Label set
  localparam int LABEL_COUNT = 10;
  localparam int ID_W        = 4;
  localparam int HDR_BYTES   = 7;
  localparam int LEN_W       = $clog2(HDR_BYTES + 1);

  localparam int TICK_W    = 32;
  localparam int HOLD_W    = 16;
  localparam int READING_W = 40;

  localparam logic [READING_W-1:0] READING_MAX    = '1;
  localparam logic [TICK_W-1:0]    TICK_MAX       = '1;
  localparam logic [HOLD_W-1:0]    HOLD_OFF_RESET = 16'd300;

  // Item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Characters
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Label codes
  localparam logic [ID_W-1:0] LBL_ADCO    = 4'd0;
  localparam logic [ID_W-1:0] LBL_ISOUS   = 4'd1;
  localparam logic [ID_W-1:0] LBL_HCHC    = 4'd2;
  localparam logic [ID_W-1:0] LBL_HCHP    = 4'd3;
  localparam logic [ID_W-1:0] LBL_IINST   = 4'd4;
  localparam logic [ID_W-1:0] LBL_IMAX    = 4'd5;
  localparam logic [ID_W-1:0] LBL_PAPP    = 4'd6;
  localparam logic [ID_W-1:0] LBL_PTEC    = 4'd7;
  localparam logic [ID_W-1:0] LBL_HHPHC   = 4'd8;
  localparam logic [ID_W-1:0] LBL_OPTARIF = 4'd9;

  // First bytes of the current line, bytes past the line end read as zero
  typedef struct packed {
    logic [POS_W-1:0]              len;
    logic [HDR_BYTES-1:0][7:0]     hdr;
  } line_stat_t;

  // Label text, first character in the low byte, unused bytes zero
  function automatic logic [HDR_BYTES*8-1:0] label_text(input logic [ID_W-1:0] id);
    unique case (id)
      LBL_ADCO:    label_text = {24'h0, "OCDA"};
      LBL_ISOUS:   label_text = {16'h0, "SUOSI"};
      LBL_HCHC:    label_text = {24'h0, "CHCH"};
      LBL_HCHP:    label_text = {24'h0, "PHCH"};
      LBL_IINST:   label_text = {16'h0, "TSNII"};
      LBL_IMAX:    label_text = {24'h0, "XAMI"};
      LBL_PAPP:    label_text = {24'h0, "PPAP"};
      LBL_PTEC:    label_text = {24'h0, "CETP"};
      LBL_HHPHC:   label_text = {16'h0, "CHPHH"};
      LBL_OPTARIF: label_text = "FIRATPO";
      default:     label_text = '0;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] label_len(input logic [ID_W-1:0] id);
    unique case (id)
      LBL_ISOUS, LBL_IINST, LBL_HHPHC: label_len = 3'd5;
      LBL_OPTARIF:                     label_len = 3'd7;
      default:                         label_len = 3'd4;
    endcase
  endfunction

  // One bit per label: the line starts with that label's text
  function automatic logic [LABEL_COUNT-1:0] label_match(
      input logic [HDR_BYTES-1:0][7:0] hdr);
    logic [HDR_BYTES*8-1:0] txt;
    logic [LEN_W-1:0]       n;
    logic                   ok;
    for (int id = 0; id < LABEL_COUNT; id++) begin
      txt = label_text(ID_W'(id));
      n   = label_len(ID_W'(id));
      ok  = 1'b1;
      for (int i = 0; i < HDR_BYTES; i++) begin
        if ((LEN_W'(i) < n) && (hdr[i] != txt[8*i +: 8])) begin
          ok = 1'b0;
        end
      end
      label_match[id] = ok;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/mlld_in_if.sv
// Input channel: received bytes and time ticks, valid/ready handshake.
// Depends on mlld_pkg.
`default_nettype none

interface mlld_in_if import mlld_pkg::*;;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/mlld_out_if.sv
// Result channel: label code and decoded reading, valid/ready handshake.
// Depends on mlld_pkg.
`default_nettype none

interface mlld_out_if import mlld_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      label_id;
  logic [READING_W-1:0] reading;

  modport source (output valid, output label_id, output reading, input ready);
  modport sink   (input valid, input label_id, input reading, output ready);
endinterface

`default_nettype wire

>>> design/mlld_cfg_if.sv
// Configuration write channel carrying the hold-off register value.
// Depends on mlld_pkg.
`default_nettype none

interface mlld_cfg_if import mlld_pkg::*;;
  logic              valid;
  logic              ready;
  logic [HOLD_W-1:0] hold_off;

  modport source (output valid, output hold_off, input ready);
  modport sink   (input valid, input hold_off, output ready);
endinterface

`default_nettype wire

>>> design/mlld_line_buf.sv
// Line store: byte memory with one write and one registered read port,
// fill count and a copy of the first bytes for label matching. Uses mlld_pkg.
`default_nettype none

module mlld_line_buf import mlld_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [7:0]       push_byte,
  input  logic             clr,
  input  logic             rd_en,
  input  logic [POS_W-1:0] rd_addr,
  output logic [7:0]       rd_data,
  output line_stat_t       stat
);

  logic [7:0]                mem [LINE_BYTES];
  logic [POS_W-1:0]          len;
  logic [HDR_BYTES-1:0][7:0] hdr;
  logic                      full;

  assign full = (len == POS_W'(LINE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[len] <= push_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Full store drops the whole line
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (clr) begin
      len <= '0;
    end else if (push) begin
      len <= full ? '0 : len + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (push && !full && (len == POS_W'(i))) begin
        hdr[i] <= push_byte;
      end
    end
  end

  // Bytes past the fill count read as zero
  always_comb begin
    stat.len = len;
    for (int i = 0; i < HDR_BYTES; i++) begin
      stat.hdr[i] = (POS_W'(i) < len) ? hdr[i] : 8'h00;
    end
  end

endmodule

`default_nettype wire

>>> design/mlld_stamp_mem.sv
// Timestamp memory: last report tick per label, registered read, with
// per-entry valid bits so unwritten entries read as zero. Uses mlld_pkg.
`default_nettype none

module mlld_stamp_mem import mlld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ID_W-1:0]   rd_addr,
  output logic [TICK_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ID_W-1:0]   wr_addr,
  input  logic [TICK_W-1:0] wr_data
);

  logic [TICK_W-1:0]      mem [LABEL_COUNT];
  logic [LABEL_COUNT-1:0] vld;
  logic [TICK_W-1:0]      q_raw;
  logic                   q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_raw <= mem[rd_addr];
      q_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = q_vld ? q_raw : '0;

endmodule

`default_nettype wire

>>> design/meter_line_label_decoder.sv
// Meter line label decoder, top level.
// Channels: din (sink) carries one item per beat: func 0 is a received byte,
// func 1 is a time tick. dout (source) carries label_id and reading. cfg
// (sink) writes the hold_off register; it is always ready.
// Bytes and ticks give no result. A line feed starts a walk: the timestamp
// memory is read once per label in order (up to ten reads, one per cycle),
// and on the first label that matches and whose hold-off has run out, the
// line store is read one character per cycle from the byte after the
// label's separator until the value ends. A line feed holds din not ready
// until the walk ends, also on a line with no report; each memory has a
// single read port.
// A result sits in an output register; the block keeps taking bytes and
// ticks while dout stalls, and a later line feed that gives a report waits
// at its end until the register is free.
// Reset: hold_off returns to 300, the line is emptied, the tick count and
// all label timestamps read as zero. No clearing pass is needed.
// Depends on mlld_pkg, the channel interfaces, mlld_line_buf, mlld_stamp_mem.
`default_nettype none

module meter_line_label_decoder import mlld_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  mlld_in_if.sink   din,
  mlld_out_if.source dout,
  mlld_cfg_if.sink  cfg
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PARSE,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [HOLD_W-1:0]    hold_off;
  logic [TICK_W-1:0]    tick_count;

  // Label scan
  logic [ID_W-1:0]      scan_id;
  logic [ID_W-1:0]      chk_id;
  logic                 chk_vld;
  logic [LABEL_COUNT-1:0] match;
  logic [TICK_W-1:0]    ts_data;
  logic                 ts_rd;
  logic                 ts_ok;
  logic                 hit;
  logic                 scan_miss;

  // Value parse
  logic [CNT_W-1:0]     rd_pos;
  logic [POS_W-1:0]     chk_pos;
  logic                 rd_vld;
  logic                 skip;
  logic                 lb_rd;
  logic [7:0]           lb_data;
  logic [7:0]           ch;
  logic                 is_space;
  logic                 is_digit;
  logic [READING_W+3:0] acc_sum;
  logic [READING_W-1:0] acc;
  logic [READING_W-1:0] acc_next;
  logic                 parse_end;
  logic [ID_W-1:0]      res_id;

  logic                 in_acc;
  logic                 is_lf;
  logic                 push;
  logic                 clr;
  logic                 can_load;
  line_stat_t           stat;

  logic                 out_valid;
  logic [ID_W-1:0]      out_id;
  logic [READING_W-1:0] out_reading;

  assign din.ready     = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign dout.valid    = out_valid;
  assign dout.label_id = out_id;
  assign dout.reading  = out_reading;

  assign in_acc = din.valid && din.ready;
  assign is_lf  = (din.rx_byte == CHAR_LF);
  assign push   = in_acc && (din.func == FUNC_BYTE) && !is_lf;

  assign can_load = !out_valid || dout.ready;

  // Scan: issue one timestamp read per cycle, check the previous one
  assign match = label_match(stat.hdr);
  assign ts_rd = (state == ST_SCAN) && (scan_id < ID_W'(LABEL_COUNT));
  assign ts_ok = ({1'b0, ts_data} + {{(TICK_W - HOLD_W + 1){1'b0}}, hold_off})
                 <= {1'b0, tick_count};
  assign hit       = (state == ST_SCAN) && chk_vld && match[chk_id] && ts_ok;
  assign scan_miss = (state == ST_SCAN) && chk_vld && !hit &&
                     (chk_id == ID_W'(LABEL_COUNT - 1));

  // Parse: bytes past the line end read as zero
  assign lb_rd    = (state == ST_PARSE) && (rd_pos < CNT_W'(LINE_BYTES));
  assign ch       = (chk_pos < stat.len) ? lb_data : 8'h00;
  assign is_space = (ch == CHAR_SPACE);
  assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign acc_sum  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
                    {{READING_W{1'b0}}, ch[3:0]};
  assign acc_next = (acc_sum > {4'h0, READING_MAX}) ? READING_MAX
                                                     : acc_sum[READING_W-1:0];
  assign parse_end = (state == ST_PARSE) &&
                     ((rd_vld && !(skip && is_space) && !is_digit) ||
                      (!rd_vld && (rd_pos == CNT_W'(LINE_BYTES))));

  assign clr = scan_miss || ((state == ST_FINISH) && can_load);

  mlld_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_byte (din.rx_byte),
    .clr       (clr),
    .rd_en     (lb_rd),
    .rd_addr   (rd_pos[POS_W-1:0]),
    .rd_data   (lb_data),
    .stat      (stat)
  );

  mlld_stamp_mem u_stamp_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (ts_rd),
    .rd_addr (scan_id),
    .rd_data (ts_data),
    .wr_en   (hit),
    .wr_addr (chk_id),
    .wr_data (tick_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hold_off   <= HOLD_OFF_RESET;
      tick_count <= '0;
      out_valid  <= 1'b0;
      chk_vld    <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        hold_off <= cfg.hold_off;
      end
      // Drop the beat once taken, unless the finish step reloads it
      if (out_valid && dout.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (din.func == FUNC_TICK) begin
              if (tick_count != TICK_MAX) begin
                tick_count <= tick_count + 1'b1;
              end
            end else if (is_lf) begin
              state   <= ST_SCAN;
              scan_id <= '0;
              chk_vld <= 1'b0;
            end
          end
        end

        ST_SCAN: begin
          chk_vld <= ts_rd;
          chk_id  <= scan_id;
          if (ts_rd) begin
            scan_id <= scan_id + 1'b1;
          end
          if (hit) begin
            state   <= ST_PARSE;
            res_id  <= chk_id;
            rd_pos  <= CNT_W'(label_len(chk_id)) + 1'b1;
            rd_vld  <= 1'b0;
            skip    <= 1'b1;
            acc     <= '0;
          end else if (scan_miss) begin
            state <= ST_IDLE;
          end
        end

        ST_PARSE: begin
          rd_vld  <= lb_rd;
          chk_pos <= rd_pos[POS_W-1:0];
          if (lb_rd) begin
            rd_pos <= rd_pos + 1'b1;
          end
          if (parse_end) begin
            state <= ST_FINISH;
          end else if (rd_vld && is_digit) begin
            acc  <= acc_next;
            skip <= 1'b0;
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free
          if (can_load) begin
            out_valid   <= 1'b1;
            out_id      <= res_id;
            out_reading <= acc;
            state       <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A line feed beat always starts a walk that blocks the input
  a_lf_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (din.func == FUNC_BYTE) && is_lf) |=> !din.ready)
    else $error("line feed accepted without starting a walk");

  // Results are loaded only at the end of a walk
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared outside the finish step");

  // The tick counter never moves backward
  a_tick_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (tick_count >= $past(tick_count)))
    else $error("tick count decreased");

  // A timestamp is written only for a label that matched the line
  a_hit_match: assert property (@(posedge clk) disable iff (rst)
    hit |-> (match[chk_id] && ($countones(match) >= 1)))
    else $error("timestamp written for a label that did not match");

endmodule

`default_nettype wire
